>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file g2l_chk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that may span cycles (|-> or |=>), sampled on the rising clock edge
`define CHK_PROP(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error(msg);

// plain condition that holds at every edge out of reset
`define CHK_COND(lbl, clk_s, rstn_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
		else $error(msg);

`endif

>>> rtl/g2l_pkg.sv
// ----------------------------------------------------------------------------
// g2l_pkg
// shared widths, constants, tables and types of the lunar date converter
// ----------------------------------------------------------------------------
`default_nettype none

package g2l_pkg;

	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WORD_W  = 24;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 24;

	// table word layout
	localparam int LEAP_LSB  = 20;
	localparam int LENS_W    = 20;

	localparam logic [4:0] SHORT_LEN = 5'd29;
	localparam logic [4:0] LONG_LEN  = 5'd30;

	// reciprocals of 10 and 12 scaled by 2^19, exact for any 12-bit year
	localparam logic [15:0] RECIP10 = 16'hCCCD;
	localparam logic [15:0] RECIP12 = 16'hAAAB;

	typedef struct packed {
		logic       leap;
		logic [4:0] lday;
		logic [3:0] lmon;
	} walk_res_t;

	typedef struct packed {
		logic       done;
		logic [3:0] stem;
		logic [3:0] branch;
	} mod_res_t;

	// days of the year before the first of the given month (1..12)
	function automatic logic [8:0] days_before(input logic [3:0] mon);
		logic [8:0] d;
		unique case (mon)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// length of the lunar month at 1-based position pos; bit 19 is the first
	function automatic logic [4:0] month_len(input logic [LENS_W-1:0] lens,
			input logic [4:0] pos);
		logic [4:0] idx;
		logic [4:0] len;
		idx = 5'd20 - pos;
		if (pos == 5'd0 || pos > 5'd20) begin
			len = SHORT_LEN;
		end else begin
			len = lens[idx] ? LONG_LEN : SHORT_LEN;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

>>> rtl/g2l_modc.sv
// ----------------------------------------------------------------------------
// g2l_modc
// year mod 10 and year mod 12 by reciprocal multiplication, quotients then remainders registered
// ----------------------------------------------------------------------------
`default_nettype none

module g2l_modc (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [g2l_pkg::YEAR_W-1:0] year,
	output g2l_pkg::mod_res_t              res
);
	import g2l_pkg::*;

	logic              step_q;
	logic              done_q;
	logic [8:0]        q10_q;
	logic [8:0]        q12_q;
	logic [3:0]        r10_q;
	logic [3:0]        r12_q;
	logic [27:0]       p10;
	logic [27:0]       p12;
	logic [YEAR_W-1:0] m10;
	logic [YEAR_W-1:0] m12;
	logic [YEAR_W-1:0] d10;
	logic [YEAR_W-1:0] d12;

	// quotients are the product bits from 19 up
	assign p10 = {16'b0, year} * {12'b0, RECIP10};
	assign p12 = {16'b0, year} * {12'b0, RECIP12};

	// quotient times divisor from two shifts, then the remainder
	assign m10 = {q10_q, 3'b0} + {2'b0, q10_q, 1'b0};
	assign m12 = {q12_q, 3'b0} + {1'b0, q12_q, 2'b0};
	assign d10 = year - m10;
	assign d12 = year - m12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			step_q <= start;
			if (start) begin
				done_q <= 1'b0;
			end else if (step_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q10_q <= p10[27:19];
			q12_q <= p12[27:19];
		end
		if (step_q) begin
			r10_q <= d10[3:0];
			r12_q <= d12[3:0];
		end
	end

	assign res.done   = done_q;
	assign res.stem   = r10_q;
	assign res.branch = r12_q;

endmodule

`default_nettype wire

>>> rtl/g2l_walk.sv
// ----------------------------------------------------------------------------
// g2l_walk
// day of year, then month walk around the spring festival on one subtractor
// ----------------------------------------------------------------------------
`default_nettype none

module g2l_walk (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [1:0]                 year_lo,
	input  wire logic [g2l_pkg::MONTH_W-1:0] month,
	input  wire logic [g2l_pkg::DAY_W-1:0]   day,
	input  wire logic [g2l_pkg::WORD_W-1:0]  cur_word,
	input  wire logic [g2l_pkg::WORD_W-1:0]  pri_word,
	output logic                            done,
	output g2l_pkg::walk_res_t              res
);
	import g2l_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	logic [1:0]        state_q;
	logic              done_q;
	walk_res_t         res_q;
	logic              fwd_q;
	logic              flag_q;
	logic [8:0]        acc_q;
	logic [4:0]        pos_q;
	logic [3:0]        lmon_q;
	logic [3:0]        leapno_q;
	logic [LENS_W-1:0] lens_q;

	logic [3:0]  gmon;
	logic [10:0] fest;
	logic [10:0] doy;
	logic [4:0]  len;
	logic [10:0] op_a;
	logic [10:0] op_b;
	logic [10:0] diff;
	logic        neg;
	logic        go;
	logic [3:0]  bwd_mon;

	// month clamped into 1..12
	always_comb begin
		if (month == 4'd0) begin
			gmon = 4'd1;
		end else if (month > 4'd12) begin
			gmon = 4'd12;
		end else begin
			gmon = month;
		end
	end

	// festival offset and day of year, both may be -1
	assign fest = {6'b0, cur_word[4:0]} - 11'd1 + ((cur_word[6:5] != 2'd1) ? 11'd31 : 11'd0);
	assign doy  = {2'b0, days_before(gmon)} + {6'b0, day} - 11'd1
		+ {10'b0, (year_lo == 2'd0) && (gmon > 4'd2)};

	assign len = month_len(lens_q, pos_q);

	// shared subtract and sign test
	assign op_a = (state_q == ST_PREP) ? doy  : {2'b0, acc_q};
	assign op_b = (state_q == ST_PREP) ? fest : {6'b0, len};
	assign diff = op_a - op_b;
	assign neg  = diff[10];
	assign go   = fwd_q ? !neg : (!neg && (diff != 11'd0));

	assign bwd_mon = flag_q ? lmon_q : lmon_q - 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (!go) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			flag_q <= 1'b0;
			if (!neg) begin
				fwd_q    <= 1'b1;
				acc_q    <= diff[8:0];
				leapno_q <= cur_word[WORD_W-1:LEAP_LSB];
				lens_q   <= cur_word[LENS_W-1:0];
				lmon_q   <= 4'd1;
				pos_q    <= 5'd1;
			end else begin
				fwd_q    <= 1'b0;
				acc_q    <= 9'(11'd0 - diff);
				leapno_q <= pri_word[WORD_W-1:LEAP_LSB];
				lens_q   <= pri_word[LENS_W-1:0];
				lmon_q   <= 4'd12;
				pos_q    <= (pri_word[WORD_W-1:LEAP_LSB] == 4'd0) ? 5'd12 : 5'd13;
			end
		end else if (state_q == ST_WALK) begin
			if (go) begin
				acc_q <= diff[8:0];
				if (fwd_q) begin
					pos_q <= pos_q + 5'd1;
					if (lmon_q == leapno_q) begin
						// leap month repeats its number
						flag_q <= !flag_q;
						if (flag_q) lmon_q <= lmon_q + 4'd1;
					end else begin
						lmon_q <= lmon_q + 4'd1;
					end
				end else begin
					pos_q  <= pos_q - 5'd1;
					lmon_q <= bwd_mon;
					if (bwd_mon == leapno_q) flag_q <= !flag_q;
				end
			end else begin
				res_q.lmon <= lmon_q;
				res_q.leap <= (lmon_q == leapno_q);
				if (fwd_q) begin
					res_q.lday <= acc_q[4:0] + 5'd1;
				end else begin
					res_q.lday <= len - acc_q[4:0] + 5'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

>>> rtl/gregorian_to_lunar_date.sv
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date
// one date is converted at a time; a new input is taken only once the result
// has moved into the output register
// the month walk on one subtractor sets the conversion time; the stem and
// branch indices are registered after the quotients, ready inside the walk
// reset: arst_n clears the sequencers and both valid flags, nothing is in flight
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_to_lunar_date (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input date and table words
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [11:0] year, [15:12] month, [20:16] day, [44:21] this_year_word,
	// [68:45] prior_year_word, [71:69] zero
	input  wire logic [g2l_pkg::IN_TDATA_W-1:0]     s_tdata,
	// converted date
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [3:0] stem_index, [7:4] branch_index, [11:8] lunar_month,
	// [16:12] lunar_day, [17] leap_match, [23:18] zero
	output logic [g2l_pkg::OUT_TDATA_W-1:0]         m_tdata
);
	import g2l_pkg::*;

	// captured transaction, held while the units work on it
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic [WORD_W-1:0]  cur_q;
	logic [WORD_W-1:0]  pri_q;

	logic busy_q;        // an item is being converted
	logic start_q;       // one-cycle kick for both units
	logic walk_done_q;   // month walk finished, held until the result goes into the output register
	logic out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic       s_acc;
	logic       finish;
	logic       walk_done;
	walk_res_t  wres;
	mod_res_t   mres;

	assign s_tready = !busy_q;
	assign s_acc    = s_tvalid && s_tready;

	// result goes out once both units are done and the output register is free
	assign finish = walk_done_q && mres.done && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			walk_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= s_acc;
			if (s_acc) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (walk_done) begin
				walk_done_q <= 1'b1;
			end else if (finish) begin
				walk_done_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload capture, no reset needed
	always_ff @(posedge clk) begin
		if (s_acc) begin
			year_q  <= s_tdata[11:0];
			month_q <= s_tdata[15:12];
			day_q   <= s_tdata[20:16];
			cur_q   <= s_tdata[44:21];
			pri_q   <= s_tdata[68:45];
		end
		if (finish) begin
			out_data_q <= {6'b0, wres.leap, wres.lday, wres.lmon, mres.branch, mres.stem};
		end
	end

	// month walk and day-of-year sequencer
	g2l_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.year_lo  (year_q[1:0]),
		.month    (month_q),
		.day      (day_q),
		.cur_word (cur_q),
		.pri_word (pri_q),
		.done     (walk_done),
		.res      (wres)
	);

	// stem and branch indices of the year
	g2l_modc u_modc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.year   (year_q),
		.res    (mres)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/g2l_chk.sv
// ----------------------------------------------------------------------------
// g2l_chk
// port-level checks of the lunar date converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module g2l_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [g2l_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import g2l_pkg::*;

	`CHK_PROP(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`CHK_PROP(a_out_stable, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
	`CHK_PROP(a_busy_after_acc, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "second item taken during conversion")
	`CHK_PROP(a_no_early_result, clk, arst_n, $rose(m_tvalid) |-> !$past(s_tvalid && s_tready), "result too soon after input")
	`CHK_COND(a_out_range, clk, arst_n, !m_tvalid || (m_tdata[3:0] <= 4'd9 && m_tdata[7:4] <= 4'd11 && m_tdata[16:12] != 5'd0), "result field out of range")

endmodule

bind gregorian_to_lunar_date g2l_chk u_g2l_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
